// ===== design/fqs_pkg.sv =====
package fqs_pkg;

    // Fixed field widths.
    localparam int VAL_W  = 32;
    localparam int MODE_W = 3;
    localparam int DIST_W = 4;

    // Default queue depth.
    localparam int DEPTH_DEFAULT = 16;

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EMPTY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic             push_en;
        logic             shift_en;
        logic [VAL_W-1:0] wr_value;
        logic [VAL_W-1:0] key;
    } fqs_ctrl_t;

    // Search token that walks the cell chain.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [DIST_W-1:0] pos;
    } fqs_tok_t;

    // One result transaction.
    typedef struct packed {
        logic              overflow;
        logic [DIST_W-1:0] distance;
        logic              found;
        logic              was_empty;
        logic [VAL_W-1:0]  data;
    } fqs_res_t;

endpackage

// ===== design/fqs_cell.sv =====
module fqs_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fqs_pkg::fqs_ctrl_t         ctrl_i,
    input  logic [CW-1:0]              count_i,
    input  logic [fqs_pkg::VAL_W-1:0]  nbr_val_i,
    output logic [fqs_pkg::VAL_W-1:0]  val_o,
    input  fqs_pkg::fqs_tok_t          tok_i,
    output fqs_pkg::fqs_tok_t          tok_o
);

    logic [fqs_pkg::VAL_W-1:0]  val_reg;
    logic                       tok_valid_reg;
    logic                       tok_found_reg;
    logic [fqs_pkg::DIST_W-1:0] tok_dist_reg;
    logic                       occupied;
    logic                       hit;

    assign occupied = CW'(IDX) < count_i;
    assign hit      = occupied && (val_reg == ctrl_i.key);

    // Storage: a pop takes the neighbor's value, a push lands in the first free cell.
    always_ff @(posedge aclk) begin
        if (ctrl_i.shift_en) begin
            val_reg <= nbr_val_i;
        end else if (ctrl_i.push_en && (count_i == CW'(IDX))) begin
            val_reg <= ctrl_i.wr_value;
        end
    end

    // The token valid bit moves one cell per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_i.valid;
        end
    end

    // The first match along the chain fixes the found flag and the distance.
    always_ff @(posedge aclk) begin
        if (tok_i.found) begin
            tok_found_reg <= 1'b1;
            tok_dist_reg  <= tok_i.pos;
        end else begin
            tok_found_reg <= hit;
            tok_dist_reg  <= hit ? fqs_pkg::DIST_W'(IDX) : '0;
        end
    end

    assign val_o       = val_reg;
    assign tok_o.valid = tok_valid_reg;
    assign tok_o.found = tok_found_reg;
    assign tok_o.pos   = tok_dist_reg;

endmodule

// ===== design/fifo_queue_with_search.sv =====
// Push, pop, peek and empty query: result is registered in the cycle after acceptance,
// and one such request can be taken every cycle while the result is drained.
// Search: a token walks the cell chain one cell per cycle, from the start register
// through every cell register into the result register; no request is taken meanwhile.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result;
// cell storage is not cleared.
module fifo_queue_with_search #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [7:0]  s_tuser,   // mode[2:0], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // data[31:0], was_empty, found, distance[3:0], overflow, zero
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [fqs_pkg::VAL_W-1:0]  key_reg;
    logic                       start_reg;
    logic                       was_empty_reg;
    logic                       m_valid_reg;
    fqs_pkg::fqs_res_t          res_reg;
    fqs_pkg::fqs_res_t          res_now;
    fqs_pkg::fqs_res_t          res_srch;
    fqs_pkg::fqs_ctrl_t         ctrl;
    fqs_pkg::fqs_tok_t          tok [DEPTH+1];
    logic [fqs_pkg::VAL_W-1:0]  cell_val [DEPTH];

    logic                        accept;
    logic [fqs_pkg::MODE_W-1:0]  mode;
    logic                        empty;
    logic                        full;
    logic                        done;

    assign mode     = s_tuser[fqs_pkg::MODE_W-1:0];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign done     = tok[DEPTH].valid;

    // Broadcast control for the cells.
    assign ctrl.push_en  = accept && (mode == fqs_pkg::MODE_PUSH) && !full;
    assign ctrl.shift_en = accept && (mode == fqs_pkg::MODE_POP) && !empty;
    assign ctrl.wr_value = s_tdata;
    assign ctrl.key      = key_reg;

    // Token entering the head cell.
    assign tok[0].valid = start_reg;
    assign tok[0].found = 1'b0;
    assign tok[0].pos   = '0;

    // Chain of cells, head at index zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [fqs_pkg::VAL_W-1:0] nbr;
        if (i == DEPTH - 1) begin : g_last
            assign nbr = cell_val[i];
        end else begin : g_mid
            assign nbr = cell_val[i+1];
        end
        fqs_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl_i    (ctrl),
            .count_i   (count_reg),
            .nbr_val_i (nbr),
            .val_o     (cell_val[i]),
            .tok_i     (tok[i]),
            .tok_o     (tok[i+1])
        );
    end

    // Result of a request that completes at once.
    always_comb begin
        res_now           = '0;
        res_now.was_empty = empty;
        case (mode)
            fqs_pkg::MODE_PUSH: begin
                res_now.overflow = full;
            end
            fqs_pkg::MODE_POP, fqs_pkg::MODE_PEEK: begin
                res_now.data = empty ? '0 : cell_val[0];
            end
            default: begin
            end
        endcase
    end

    // Result of a search once the token leaves the chain.
    always_comb begin
        res_srch           = '0;
        res_srch.was_empty = was_empty_reg;
        res_srch.found     = tok[DEPTH].found;
        res_srch.distance  = tok[DEPTH].pos;
    end

    // Fill count.
    always_comb begin
        count_next = count_reg;
        if (ctrl.push_en) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.shift_en) begin
            count_next = count_reg - CW'(1);
        end
    end

    // Sequencer: idle, or waiting for the search token to leave the chain.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (mode == fqs_pkg::MODE_SEARCH)) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= accept && (mode == fqs_pkg::MODE_SEARCH);
            if (accept && (mode != fqs_pkg::MODE_SEARCH)) begin
                m_valid_reg <= 1'b1;
            end else if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Search key and result payload.
    always_ff @(posedge aclk) begin
        if (accept && (mode == fqs_pkg::MODE_SEARCH)) begin
            key_reg       <= s_tdata;
            was_empty_reg <= empty;
        end
        if (accept && (mode != fqs_pkg::MODE_SEARCH)) begin
            res_reg <= res_now;
        end else if (done) begin
            res_reg <= res_srch;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, res_reg};

endmodule

// ===== design/fqs_checker.sv =====
module fqs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [7:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A request is taken only when the output register is free or draining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("request taken while result was stuck");

    // A request other than search delivers its result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[2:0] != fqs_pkg::MODE_SEARCH) |=> m_tvalid)
        else $error("immediate result missing");

    // Reset drops any pending result.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (.*);

// ===== verif/fqs_queue_checker.sv =====
// Watches both channels of the queue, predicts each result from its own copy of the
// queue contents, and compares every result transaction with the oldest prediction.
module fqs_queue_checker #(
    parameter int DEPTH = fqs_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [7:0]  s_tuser,   // mode[2:0], zeros above
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // data[31:0], was_empty, found, distance[3:0], overflow, zero
    output int          mismatch_count,
    output int          results_pending
);

    // Shadow of the queue, head at index 0.
    logic [fqs_pkg::VAL_W-1:0] queue_model[$];

    // Predicted results still waiting for their transaction on the result channel.
    fqs_pkg::fqs_res_t expected_results[$];

    // Apply one request to the shadow queue and return the result it should produce.
    function automatic fqs_pkg::fqs_res_t predict_queue_result(
        input logic [fqs_pkg::MODE_W-1:0] mode,
        input logic [fqs_pkg::VAL_W-1:0]  value);
        fqs_pkg::fqs_res_t res;
        res           = '0;
        res.was_empty = (queue_model.size() == 0);
        case (mode)
            fqs_pkg::MODE_PUSH: begin
                if (queue_model.size() >= DEPTH)
                    res.overflow = 1'b1;
                else
                    queue_model.push_back(value);
            end
            fqs_pkg::MODE_POP: begin
                if (queue_model.size() != 0)
                    res.data = queue_model.pop_front();
            end
            fqs_pkg::MODE_PEEK: begin
                if (queue_model.size() != 0)
                    res.data = queue_model[0];
            end
            fqs_pkg::MODE_SEARCH: begin
                // The first match counted from the head wins.
                for (int k = 0; k < queue_model.size(); k++) begin
                    if (queue_model[k] == value) begin
                        res.found    = 1'b1;
                        res.distance = fqs_pkg::DIST_W'(k);
                        break;
                    end
                end
            end
            default: begin
                // Unused modes only report the occupancy.
            end
        endcase
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Compare one result transaction with the oldest prediction, field by field.
    task automatic compare_result(input fqs_pkg::fqs_res_t got);
        fqs_pkg::fqs_res_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending, data", got.data, '0);
        end else begin
            want = expected_results.pop_front();
            if (got.data !== want.data)
                report_mismatch("data", got.data, want.data);
            if (got.was_empty !== want.was_empty)
                report_mismatch("was_empty", 32'(got.was_empty), 32'(want.was_empty));
            if (got.found !== want.found)
                report_mismatch("found", 32'(got.found), 32'(want.found));
            if (got.distance !== want.distance)
                report_mismatch("distance", 32'(got.distance), 32'(want.distance));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
        end
    endtask

    // Track both channels; results always trail their request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            queue_model.delete();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                compare_result(fqs_pkg::fqs_res_t'(m_tdata[$bits(fqs_pkg::fqs_res_t)-1:0]));
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    predict_queue_result(s_tuser[fqs_pkg::MODE_W-1:0], s_tdata));
        end
        results_pending = expected_results.size();
    end

endmodule

// ===== verif/tb_fifo_queue_with_search.sv =====
// Drives request and result channels of the search queue with random idling and
// gives the verdict from the checker's mismatch count.
module tb_fifo_queue_with_search;

    localparam int DEPTH       = fqs_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_REQS = 1450;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    int mismatch_count;
    int results_pending;

    // Idling is switched off for one long stretch of the random part.
    bit idle_on = 1'b1;

    // Values that recur so that searches hit and duplicates appear.
    logic [31:0] value_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_55AA,
                                   32'hA5A5_0F0F, 32'h0000_0007};

    fifo_queue_with_search #(.DEPTH(DEPTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fqs_queue_checker #(.DEPTH(DEPTH)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Clock with a period of 12.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side stalls at random while idling is on.
    always @(posedge aclk) begin
        if (idle_on)
            m_tready <= ($urandom_range(99) >= 27);
        else
            m_tready <= 1'b1;
    end

    // Present one request, with random gaps before it, and hold it until accepted.
    task automatic send_request(input logic [fqs_pkg::MODE_W-1:0] mode,
                                input logic [31:0] value);
        while (idle_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {{(8 - fqs_pkg::MODE_W){1'b0}}, mode};
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Values come from the pool half of the time and are fully random otherwise.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    initial begin
        int bias;
        int roll;
        int guard;
        logic [fqs_pkg::MODE_W-1:0] mode;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Requests on an empty queue, and the unused modes.
        send_request(fqs_pkg::MODE_POP, 32'h0);
        send_request(fqs_pkg::MODE_PEEK, 32'h0);
        send_request(fqs_pkg::MODE_EMPTY, 32'h0);
        send_request(fqs_pkg::MODE_SEARCH, 32'h0);
        send_request(3'd5, 32'hFFFF_FFFF);
        send_request(3'd6, 32'h0);
        send_request(3'd7, 32'h5A5A_5A5A);

        // Extreme values, then peek and search near the head.
        send_request(fqs_pkg::MODE_PUSH, 32'h8000_0000);
        send_request(fqs_pkg::MODE_PUSH, 32'h7FFF_FFFF);
        send_request(fqs_pkg::MODE_PUSH, 32'hFFFF_FFFF);
        send_request(fqs_pkg::MODE_PUSH, 32'h0000_0000);
        send_request(fqs_pkg::MODE_EMPTY, 32'h0);
        send_request(fqs_pkg::MODE_PEEK, 32'h0);
        send_request(fqs_pkg::MODE_SEARCH, 32'h7FFF_FFFF);
        send_request(fqs_pkg::MODE_SEARCH, 32'h1234_5678);

        // Fill to the brim, push once more, and find the tail entry.
        for (int i = 4; i < DEPTH; i++)
            send_request(fqs_pkg::MODE_PUSH, 32'h0100_0000 + i);
        send_request(fqs_pkg::MODE_PUSH, 32'hDEAD_BEEF);
        send_request(fqs_pkg::MODE_SEARCH, 32'h0100_0000 + DEPTH - 1);
        send_request(fqs_pkg::MODE_POP, 32'h0);

        // Random part: the mix of pushes and pops drifts to sweep the fill level.
        bias = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 48 == 0)
                bias = $urandom_range(2);
            idle_on = !(n >= 500 && n < 850);
            roll = $urandom_range(99);
            if (roll < 3)
                mode = 3'($urandom_range(7, 5));
            else if (roll < 3 + (bias == 0 ? 55 : (bias == 1 ? 20 : 35)))
                mode = fqs_pkg::MODE_PUSH;
            else if (roll < 73)
                mode = (bias == 1) ? fqs_pkg::MODE_POP : fqs_pkg::MODE_SEARCH;
            else if (roll < 85)
                mode = fqs_pkg::MODE_POP;
            else if (roll < 90)
                mode = fqs_pkg::MODE_PEEK;
            else if (roll < 93)
                mode = fqs_pkg::MODE_EMPTY;
            else
                mode = fqs_pkg::MODE_SEARCH;
            send_request(mode, pick_value());
        end
        idle_on = 1'b1;
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then give the verdict.
        guard = 0;
        while (results_pending != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DEPTH + 4) @(posedge aclk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(12 * 400000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== fifo_queue_with_search.f =====
design/fqs_pkg.sv
design/fqs_cell.sv
design/fifo_queue_with_search.sv
design/fqs_checker.sv
verif/fqs_queue_checker.sv
verif/tb_fifo_queue_with_search.sv
